FILE: rtl/core/gamepad_keystroke_generator_macros.svh
// Assertion macros for the gamepad keystroke generator
`ifndef GAMEPAD_KEYSTROKE_GENERATOR_MACROS_SVH
`define GAMEPAD_KEYSTROKE_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define GKG_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GKG_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gkg_pkg.sv
// Types, constants and helpers shared by the keystroke generator
package gkg_pkg;

  localparam int KEY_COUNT = 34;
  localparam int KEY_IDX_W = 6;
  localparam logic [KEY_IDX_W-1:0] KEY_UNUSED = 6'd11;
  localparam int LTRIG_BIT = 16;
  localparam int RTRIG_BIT = 17;
  localparam int LSTICK_BASE = 18;
  localparam int RSTICK_BASE = 26;
  localparam int DIAG_OFFSET = 4;

  // mid queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_REPEAT_DELAY = 2'd0;
  localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] CFG_TRIG_THRESH = 2'd2;
  localparam logic [1:0] CFG_STICK_THRESH = 2'd3;

  localparam logic [15:0] RST_REPEAT_DELAY = 16'd400;
  localparam logic [15:0] RST_REPEAT_PERIOD = 16'd100;
  localparam logic [7:0] RST_TRIG_THRESH = 8'd64;
  localparam logic [14:0] RST_STICK_THRESH = 15'd16384;

  typedef logic [KEY_COUNT-1:0] keys_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_WAITING   = 2'd1,
    MODE_REPEATING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DOWN   = 2'd0,
    KIND_UP     = 2'd1,
    KIND_REPEAT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_period_ms;
    logic [7:0]  trigger_threshold;
    logic [14:0] stick_threshold;
  } cfg_t;

  // classified poll word handed from front to back
  typedef struct packed {
    keys_t       keys;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic     event_valid;
    key_idx_t key_index;
    kind_t    event_kind;
  } result_t;

  // index of the lowest set bit; zero when none set
  function automatic key_idx_t lowest_set(input keys_t v);
    key_idx_t idx;
    idx = '0;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (v[i]) idx = KEY_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/gkg_front.sv
// Front end: turns a pad snapshot into the 34-bit key field
module gkg_front (
  input  gkg_pkg::cfg_t  cfg,
  input  logic [15:0]    button_bits,
  input  logic [7:0]     left_trigger_level,
  input  logic [7:0]     right_trigger_level,
  input  logic [15:0]    left_stick_x,
  input  logic [15:0]    left_stick_y,
  input  logic [15:0]    right_stick_x,
  input  logic [15:0]    right_stick_y,
  input  logic           input_enabled,
  input  logic [31:0]    now_ms,
  output gkg_pkg::poll_t poll
);
  import gkg_pkg::*;

  // eight directions: up, down, right, left, then diagonals ul, ur, dr, dl
  function automatic logic [7:0] stick_dirs(input logic [15:0] x, input logic [15:0] y,
                                            input logic [14:0] thr);
    logic [15:0] pos;
    logic [15:0] neg;
    logic u, d, r, l;
    pos = {1'b0, thr};
    neg = ~pos;  // -(thr+1)
    u = $signed(y) > $signed(pos);
    d = $signed(y) < $signed(neg);
    r = $signed(x) > $signed(pos);
    l = $signed(x) < $signed(neg);
    return {d & l, d & r, u & r, u & l, l & ~u & ~d, r & ~u & ~d, d & ~l & ~r, u & ~l & ~r};
  endfunction

  keys_t keys;

  always_comb begin
    keys = '0;
    if (input_enabled) begin
      keys[15:0] = button_bits;
      keys[LTRIG_BIT] = left_trigger_level > cfg.trigger_threshold;
      keys[RTRIG_BIT] = right_trigger_level > cfg.trigger_threshold;
      keys[LSTICK_BASE +: 8] = stick_dirs(left_stick_x, left_stick_y, cfg.stick_threshold);
      keys[RSTICK_BASE +: 8] = stick_dirs(right_stick_x, right_stick_y, cfg.stick_threshold);
    end
    // key eleven never reports: drop it here so it never differs
    keys[KEY_UNUSED] = 1'b0;
  end

  assign poll.keys = keys;
  assign poll.now_ms = now_ms;

endmodule

FILE: rtl/core/gkg_queue.sv
// Short word queue between front and back
module gkg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gkg_pkg::poll_t push_data,
  output logic           full,
  input  logic           pop,
  output gkg_pkg::poll_t pop_data,
  output logic           empty
);
  import gkg_pkg::*;

  poll_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full = cnt_r == (QAW+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(do_push);
    rd_ptr_nxt = rd_ptr_r + QAW'(do_pop);
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/core/gkg_back.sv
// Back end: key diff, typematic repeat timer and result queue
module gkg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gkg_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  gkg_pkg::poll_t   q_data,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output gkg_pkg::result_t out_word
);
  import gkg_pkg::*;

  keys_t       rep_r, rep_nxt;
  mode_t       mode_r, mode_nxt;
  key_idx_t    rkey_r, rkey_nxt;
  logic [31:0] stamp_r, stamp_nxt;

  result_t     o_mem_r [2];
  logic        o_wr_r, o_rd_r;
  logic [1:0]  o_cnt_r, o_cnt_nxt;
  logic        o_room, step, o_pop_ok;

  logic [31:0] elapsed;
  mode_t       mode_mid;
  logic        fire;
  keys_t       up_vec, dn_vec;
  key_idx_t    up_idx, dn_idx;
  result_t     res;

  assign o_pop_ok = out_pop && (o_cnt_r != 2'd0);
  assign o_room = (o_cnt_r != 2'd2) || out_pop;
  assign step = !q_empty && o_room;
  assign q_pop = step;

  assign elapsed = q_data.now_ms - stamp_r;
  assign up_vec = rep_r & ~q_data.keys;
  assign dn_vec = q_data.keys & ~rep_r;
  assign up_idx = lowest_set(up_vec);
  assign dn_idx = lowest_set(dn_vec);

  always_comb begin
    case (mode_r)
      MODE_WAITING:   mode_mid = (elapsed > {16'd0, cfg.repeat_delay_ms}) ?
                                 MODE_REPEATING : MODE_WAITING;
      MODE_REPEATING: mode_mid = MODE_REPEATING;
      default:        mode_mid = MODE_IDLE;
    endcase
    fire = (mode_mid == MODE_REPEATING) && (elapsed > {16'd0, cfg.repeat_period_ms});

    rep_nxt = rep_r;
    mode_nxt = mode_mid;
    rkey_nxt = rkey_r;
    stamp_nxt = stamp_r;
    res = '{event_valid: 1'b0, key_index: '0, event_kind: KIND_DOWN};
    if (fire) begin
      stamp_nxt = q_data.now_ms;
      res = '{event_valid: 1'b1, key_index: rkey_r, event_kind: KIND_REPEAT};
    end else if (|up_vec) begin
      rep_nxt[up_idx] = 1'b0;
      mode_nxt = MODE_IDLE;
      res = '{event_valid: 1'b1, key_index: up_idx, event_kind: KIND_UP};
    end else if (|dn_vec) begin
      rep_nxt[dn_idx] = 1'b1;
      mode_nxt = MODE_WAITING;
      rkey_nxt = dn_idx;
      stamp_nxt = q_data.now_ms;
      res = '{event_valid: 1'b1, key_index: dn_idx, event_kind: KIND_DOWN};
    end

    o_cnt_nxt = o_cnt_r + 2'(step) - 2'(o_pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= '0;
      mode_r <= MODE_IDLE;
      rkey_r <= '0;
      stamp_r <= '0;
      o_wr_r <= 1'b0;
      o_rd_r <= 1'b0;
      o_cnt_r <= '0;
    end else begin
      if (step) begin
        rep_r <= rep_nxt;
        mode_r <= mode_nxt;
        rkey_r <= rkey_nxt;
        stamp_r <= stamp_nxt;
        o_wr_r <= ~o_wr_r;
      end
      if (o_pop_ok) o_rd_r <= ~o_rd_r;
      o_cnt_r <= o_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) o_mem_r[o_wr_r] <= res;
  end

  assign out_empty = o_cnt_r == 2'd0;
  assign out_word = o_mem_r[o_rd_r];

endmodule

FILE: rtl/core/gamepad_keystroke_generator.sv
// Top level of the gamepad keystroke generator
//
//   channel  direction  handshake         payload
//   in_      into block push / full       pad snapshot, enable, now_ms
//   out_     from block empty / pop       event_valid, key_index, event_kind
//   cfg_     into block cfg_we            cfg_index, cfg_wdata
//
// One poll per cycle sustained while full stays low; a result word reaches the out_ ports once its poll
// is taken: the poll is written into the front queue, then the back step writes the result queue.
// The back step is combinational: repeat timer compare plus 34-bit key diff.
// Reset is synchronous on rst_n; all queues empty, key state and config to defaults.
// full rises when the four-entry front queue is occupied; the back stalls only
// while both result queue entries are held and pop is low.
module gamepad_keystroke_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_button_bits,
  input  logic [7:0]  in_left_trigger_level,
  input  logic [7:0]  in_right_trigger_level,
  input  logic [15:0] in_left_stick_x,
  input  logic [15:0] in_left_stick_y,
  input  logic [15:0] in_right_stick_x,
  input  logic [15:0] in_right_stick_y,
  input  logic        in_input_enabled,
  input  logic [31:0] in_now_ms,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_event_valid,
  output logic [5:0]  out_key_index,
  output logic [1:0]  out_event_kind
);
  import gkg_pkg::*;
  `include "gamepad_keystroke_generator_macros.svh"

  cfg_t    cfg_r;
  poll_t   f_poll;
  poll_t   q_data;
  logic    q_empty, q_pop;
  result_t out_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_delay_ms <= RST_REPEAT_DELAY;
      cfg_r.repeat_period_ms <= RST_REPEAT_PERIOD;
      cfg_r.trigger_threshold <= RST_TRIG_THRESH;
      cfg_r.stick_threshold <= RST_STICK_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPEAT_DELAY:  cfg_r.repeat_delay_ms <= cfg_wdata;
        CFG_REPEAT_PERIOD: cfg_r.repeat_period_ms <= cfg_wdata;
        CFG_TRIG_THRESH:   cfg_r.trigger_threshold <= cfg_wdata[7:0];
        CFG_STICK_THRESH:  cfg_r.stick_threshold <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  gkg_front u_front (
    .cfg                 (cfg_r),
    .button_bits         (in_button_bits),
    .left_trigger_level  (in_left_trigger_level),
    .right_trigger_level (in_right_trigger_level),
    .left_stick_x        (in_left_stick_x),
    .left_stick_y        (in_left_stick_y),
    .right_stick_x       (in_right_stick_x),
    .right_stick_y       (in_right_stick_y),
    .input_enabled       (in_input_enabled),
    .now_ms              (in_now_ms),
    .poll                (f_poll)
  );

  gkg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (f_poll),
    .full      (in_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  gkg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

  assign out_event_valid = out_word.event_valid;
  assign out_key_index = out_word.key_index;
  assign out_event_kind = out_word.event_kind;

  // key eleven must never come out
  `GKG_CHECK(a_no_key_eleven, !out_empty && out_event_valid, out_key_index != KEY_UNUSED, "key eleven reported")
  // a quiet word carries all-zero fields
  `GKG_CHECK(a_quiet_zero, !out_empty && !out_event_valid, out_key_index == '0 && out_event_kind == KIND_DOWN, "quiet word not zero")
  // a taken poll is waiting in the front queue next cycle
  `GKG_CHECK_NEXT(a_poll_queued, in_push && !in_full, !q_empty, "taken poll lost")

endmodule

FILE: verif/gkg_event_checker.sv
// Keystroke event predictor and scoreboard for the gamepad keystroke generator
module gkg_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [15:0] in_button_bits,
  input  logic [7:0]  in_left_trigger_level,
  input  logic [7:0]  in_right_trigger_level,
  input  logic [15:0] in_left_stick_x,
  input  logic [15:0] in_left_stick_y,
  input  logic [15:0] in_right_stick_x,
  input  logic [15:0] in_right_stick_y,
  input  logic        in_input_enabled,
  input  logic [31:0] in_now_ms,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_event_valid,
  input  logic [5:0]  out_key_index,
  input  logic [1:0]  out_event_kind,
  output int          events_owed,
  output int          mismatches
);
  import gkg_pkg::*;

  cfg_t        regs;
  keys_t       held_keys;
  mode_t       rpt_mode;
  key_idx_t    rpt_key;
  logic [31:0] rpt_stamp;
  result_t     owed_q[$];
  int          err_n = 0;

  // eight-way direction of one stick; diagonals claim their two axes first
  function automatic logic [7:0] stick_dirs(input logic [15:0] xr, input logic [15:0] yr,
                                            input logic [14:0] thr);
    int x, y, pos;
    logic u, d, r, l;
    logic [7:0] f;
    x = int'($signed(xr));
    y = int'($signed(yr));
    pos = int'(thr);
    u = y > pos;
    d = y < -pos - 1;
    r = x > pos;
    l = x < -pos - 1;
    f = '0;
    if (u && l) begin
      u = 1'b0; l = 1'b0; f[DIAG_OFFSET] = 1'b1;
    end
    if (u && r) begin
      u = 1'b0; r = 1'b0; f[DIAG_OFFSET + 1] = 1'b1;
    end
    if (d && r) begin
      d = 1'b0; r = 1'b0; f[DIAG_OFFSET + 2] = 1'b1;
    end
    if (d && l) begin
      d = 1'b0; l = 1'b0; f[DIAG_OFFSET + 3] = 1'b1;
    end
    f[0] = u;
    f[1] = d;
    f[2] = r;
    f[3] = l;
    return f;
  endfunction

  function automatic keys_t pad_keys();
    keys_t k;
    k = '0;
    if (in_input_enabled) begin
      k[15:0] = in_button_bits;
      k[LTRIG_BIT] = in_left_trigger_level > regs.trigger_threshold;
      k[RTRIG_BIT] = in_right_trigger_level > regs.trigger_threshold;
      k[LSTICK_BASE +: 8] = stick_dirs(in_left_stick_x, in_left_stick_y, regs.stick_threshold);
      k[RSTICK_BASE +: 8] = stick_dirs(in_right_stick_x, in_right_stick_y,
                                       regs.stick_threshold);
    end
    return k;
  endfunction

  // repeat first, then lowest release, then lowest press
  function automatic result_t next_event(input keys_t cur, input logic [31:0] now);
    result_t ev;
    keys_t diff;
    logic [31:0] elapsed;
    ev = '0;
    elapsed = now - rpt_stamp;
    if (rpt_mode == MODE_WAITING && elapsed > regs.repeat_delay_ms)
      rpt_mode = MODE_REPEATING;
    if (rpt_mode == MODE_REPEATING && elapsed > regs.repeat_period_ms) begin
      rpt_stamp = now;
      ev.event_valid = 1'b1;
      ev.key_index = rpt_key;
      ev.event_kind = KIND_REPEAT;
      return ev;
    end
    diff = cur ^ held_keys;
    diff[KEY_UNUSED] = 1'b0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (diff[i] && !cur[i]) begin
        held_keys[i] = 1'b0;
        rpt_mode = MODE_IDLE;
        ev.event_valid = 1'b1;
        ev.key_index = key_idx_t'(i);
        ev.event_kind = KIND_UP;
        return ev;
      end
    end
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (diff[i] && cur[i]) begin
        held_keys[i] = 1'b1;
        rpt_mode = MODE_WAITING;
        rpt_key = key_idx_t'(i);
        rpt_stamp = now;
        ev.event_valid = 1'b1;
        ev.key_index = key_idx_t'(i);
        ev.event_kind = KIND_DOWN;
        return ev;
      end
    end
    return ev;
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    if (!rst_n) begin
      regs.repeat_delay_ms = RST_REPEAT_DELAY;
      regs.repeat_period_ms = RST_REPEAT_PERIOD;
      regs.trigger_threshold = RST_TRIG_THRESH;
      regs.stick_threshold = RST_STICK_THRESH;
      held_keys = '0;
      rpt_mode = MODE_IDLE;
      rpt_key = '0;
      rpt_stamp = '0;
      owed_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (owed_q.size() == 0) begin
          $error("unexpected word: valid %0d key %0d kind %0d",
                 out_event_valid, out_key_index, out_event_kind);
          err_n++;
        end else begin
          want = owed_q.pop_front();
          if (out_event_valid !== want.event_valid) begin
            $error("event_valid: expected %0d, got %0d", want.event_valid, out_event_valid);
            err_n++;
          end
          if (out_key_index !== want.key_index) begin
            $error("key_index: expected %0d, got %0d", want.key_index, out_key_index);
            err_n++;
          end
          if (out_event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, out_event_kind);
            err_n++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPEAT_DELAY:  regs.repeat_delay_ms = cfg_wdata;
          CFG_REPEAT_PERIOD: regs.repeat_period_ms = cfg_wdata;
          CFG_TRIG_THRESH:   regs.trigger_threshold = cfg_wdata[7:0];
          CFG_STICK_THRESH:  regs.stick_threshold = cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        owed_q.push_back(next_event(pad_keys(), in_now_ms));
    end
    events_owed <= owed_q.size();
    mismatches <= err_n;
  end

endmodule

FILE: verif/gamepad_keystroke_generator_tb.sv
// Stimulus and verdict for the gamepad keystroke generator
module gamepad_keystroke_generator_tb;
  import gkg_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 7;
  localparam int PHASE_WORDS = 290;

  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  ltrig;
    logic [7:0]  rtrig;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
    logic        en;
    logic [31:0] now;
  } pad_poll_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_button_bits = '0;
  logic [7:0]  in_left_trigger_level = '0;
  logic [7:0]  in_right_trigger_level = '0;
  logic [15:0] in_left_stick_x = '0;
  logic [15:0] in_left_stick_y = '0;
  logic [15:0] in_right_stick_x = '0;
  logic [15:0] in_right_stick_y = '0;
  logic        in_input_enabled = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_event_valid;
  logic [5:0]  out_key_index;
  logic [1:0]  out_event_kind;
  int          events_owed;
  int          mismatches;

  bit          steady = 1'b0;
  int unsigned cycles = 0;
  cfg_t        cur_cfg;
  pad_poll_t   pad;
  logic [31:0] ms_clock;
  int unsigned step_max;

  gamepad_keystroke_generator u_top (.*);
  gkg_event_checker u_events (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= steady || ($urandom_range(99) >= 33);
  end

  task automatic send_poll(input pad_poll_t p);
    // idle cycle by cycle, about a third of the time
    while (!steady && $urandom_range(99) < 33) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_button_bits <= p.buttons;
    in_left_trigger_level <= p.ltrig;
    in_right_trigger_level <= p.rtrig;
    in_left_stick_x <= p.lx;
    in_left_stick_y <= p.ly;
    in_right_stick_x <= p.rx;
    in_right_stick_y <= p.ry;
    in_input_enabled <= p.en;
    in_now_ms <= p.now;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic poll_at(input logic [31:0] now);
    pad.now = now;
    send_poll(pad);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (events_owed != 0) @(posedge clk);
  endtask

  // back-to-back writes so cfg_we is only raised once
  task automatic set_config(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REPEAT_DELAY;
    cfg_wdata <= c.repeat_delay_ms;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_PERIOD;
    cfg_wdata <= c.repeat_period_ms;
    @(posedge clk);
    cfg_index <= CFG_TRIG_THRESH;
    cfg_wdata <= {8'h00, c.trigger_threshold};
    @(posedge clk);
    cfg_index <= CFG_STICK_THRESH;
    cfg_wdata <= {1'b0, c.stick_threshold};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    c = cur_cfg;
    case (p)
      1: c = '{16'd0, 16'd0, 8'd0, 15'd0};
      2: c = '{16'hFFFF, 16'hFFFF, 8'hFF, 15'h7FFF};
      3: c = '{16'd12, 16'd4, 8'd100, 15'd8000};
      4: c = '{16'd5, 16'd20, 8'd200, 15'd30000};   // period longer than delay
      5: c = '{16'($urandom), 16'($urandom), 8'($urandom), 15'($urandom)};
      default: c = '{RST_REPEAT_DELAY, RST_REPEAT_PERIOD, RST_TRIG_THRESH, RST_STICK_THRESH};
    endcase
    return c;
  endfunction

  // axis values either side of the current threshold, plus the rails, zero and a random value
  function automatic logic [15:0] near_edge(input logic [14:0] thr);
    logic [15:0] t;
    t = {1'b0, thr};
    case ($urandom_range(7))
      0: return t;
      1: return t + 16'd1;
      2: return -t - 16'd1;
      3: return -t - 16'd2;
      4: return 16'h7FFF;
      5: return 16'h8000;
      6: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly small changes to a held pad so presses, releases and repeats play out
  task automatic next_pad();
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      // pad held as it is
    end else if (r < 70) begin
      pad.buttons[$urandom_range(15)] = ~pad.buttons[$urandom_range(15)];
    end else if (r < 76) begin
      if ($urandom_range(1)) pad.ltrig = 8'($urandom);
      else pad.rtrig = 8'($urandom);
    end else if (r < 86) begin
      case ($urandom_range(3))
        0: pad.lx = near_edge(cur_cfg.stick_threshold);
        1: pad.ly = near_edge(cur_cfg.stick_threshold);
        2: pad.rx = near_edge(cur_cfg.stick_threshold);
        default: pad.ry = near_edge(cur_cfg.stick_threshold);
      endcase
    end else if (r < 89) begin
      pad.en = ~pad.en;
    end else if (r < 96) begin
      pad.buttons = 16'($urandom);
      pad.ltrig = 8'($urandom);
      pad.rtrig = 8'($urandom);
      pad.lx = 16'($urandom);
      pad.ly = 16'($urandom);
      pad.rx = 16'($urandom);
      pad.ry = 16'($urandom);
    end else begin
      pad.buttons = '0;
      pad.ltrig = '0;
      pad.rtrig = '0;
      pad.lx = '0;
      pad.ly = '0;
      pad.rx = '0;
      pad.ry = '0;
    end
    if (!pad.en && $urandom_range(99) < 40) pad.en = 1'b1;
    if ($urandom_range(99) < 2) ms_clock = $urandom;
    else ms_clock = ms_clock + $urandom_range(0, step_max);
    pad.now = ms_clock;
  endtask

  initial begin
    cur_cfg = '{RST_REPEAT_DELAY, RST_REPEAT_PERIOD, RST_TRIG_THRESH, RST_STICK_THRESH};
    pad = '0;
    pad.en = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset settings
    poll_at(32'd0);
    pad.buttons = 16'h0800;                // key eleven alone: silent
    poll_at(32'd5);
    pad.buttons = 16'h8000;
    poll_at(32'd10);
    poll_at(32'd411);                      // just past the delay: repeat
    poll_at(32'd511);                      // exactly one period: nothing
    poll_at(32'd512);
    pad.ltrig = 8'd64;                     // at threshold: not pressed
    pad.rtrig = 8'd65;
    poll_at(32'd513);
    pad.ltrig = 8'd255;
    pad.rtrig = 8'd0;
    poll_at(32'd514);
    poll_at(32'd515);
    pad.lx = 16'd16384;
    pad.ly = 16'd16385;
    poll_at(32'd516);
    pad.lx = -16'sd16385;
    pad.ly = -16'sd16386;
    poll_at(32'd517);
    poll_at(32'd518);
    pad.rx = 16'h7FFF;
    pad.ry = 16'h7FFF;
    poll_at(32'd519);
    pad.rx = 16'h8000;
    pad.ry = 16'h8000;
    poll_at(32'd520);
    poll_at(32'd521);
    pad.lx = 16'h8000;
    pad.ly = 16'h7FFF;
    poll_at(32'd522);
    poll_at(32'd523);
    pad.lx = 16'h7FFF;
    pad.ly = 16'h8000;
    poll_at(32'd524);
    poll_at(32'd525);
    pad.en = 1'b0;                          // everything reads released
    repeat (4) poll_at(32'd530);
    pad = '0;
    pad.en = 1'b1;
    pad.buttons = 16'h0001;
    pad.rx = 16'd16385;
    poll_at(32'hFFFF_FF00);
    poll_at(32'hFFFF_FF01);
    poll_at(32'h0000_0100);                // timer across the wrap of now_ms
    ms_clock = 32'h0000_0100;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        set_config(phase_cfg(p));
      end
      steady <= (p == 3);
      step_max = cur_cfg.repeat_delay_ms / 8 + cur_cfg.repeat_period_ms / 4 + 3;
      repeat (PHASE_WORDS) begin
        next_pad();
        send_poll(pad);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/gkg_pkg.sv
rtl/core/gkg_front.sv
rtl/core/gkg_queue.sv
rtl/core/gkg_back.sv
rtl/core/gamepad_keystroke_generator.sv
verif/gkg_event_checker.sv
verif/gamepad_keystroke_generator_tb.sv
